// ===== rtl/mzjt_pkg.sv =====
// Shared types and constants of the multi-zone job timer.
`timescale 1ns / 1ps

package mzjt_pkg;

	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_START  = 2'd1;
	localparam logic [1:0] FUNC_STOP   = 2'd2;
	localparam logic [1:0] FUNC_BUTTON = 2'd3;

	localparam logic [1:0] KIND_STOP_ACK = 2'd0;
	localparam logic [1:0] KIND_DONE     = 2'd1;
	localparam logic [1:0] KIND_TOGGLE   = 2'd2;

	localparam logic [15:0] TPM_RESET = 16'd1200;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  zone;
		logic [31:0] job_id;
		logic        job_id_valid;
		logic        request_on;
		logic [7:0]  valve_mask;
		logic        last;
	} report_t;

endpackage

// ===== rtl/multi_zone_job_timer_core.sv =====
// Top level of the multi-zone job timer: sequencer, zone state and configuration.
`timescale 1ns / 1ps

// Usage: one item enters on the in_valid/in_stall channel and carries a base tick,
// a job start, a job stop or a button event. Reports leave on the out_valid/out_stall
// channel, one transaction each, and the final report of an item has last set.
// The block works on one item at a time and holds in_stall high until that item
// is finished. A tick that ends a minute has the shared increment and compare unit
// walk the zones in turn and then emits one completion report per finished zone.
// A stop emits an acknowledge and then a completion report, and a button event a
// toggle when a button is active, each waiting out any output stall. Each report
// is held in the output register on its way to the output. The single output
// register takes a new report in the cycle that the receiver takes the previous
// one; when the receiver stalls, the sequencer waits with it.
// The minute length in base ticks is written through cfg_valid/cfg_ready/cfg_data
// while idle. Reset closes all valves, clears every job and the prescaler, and sets
// the minute length to 1200 base ticks.

module multi_zone_job_timer_core #(
	parameter int ZONE_COUNT = 8,
	parameter int ID_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  zone,
	input  logic [15:0] duration,
	input  logic [31:0] cmd_id,
	input  logic [7:0]  button_now,
	input  logic [7:0]  button_captured,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  report_kind,
	output logic [2:0]  zone_out,
	output logic [31:0] job_id_out,
	output logic        job_id_valid,
	output logic        request_on,
	output logic [7:0]  valve_mask,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int ZW   = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
	localparam int ID_W = (ID_BITS < 32) ? ID_BITS : 32;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TICK  = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_EMIT  = 3'd3;
	localparam logic [2:0] S_STOP1 = 3'd4;
	localparam logic [2:0] S_STOP2 = 3'd5;
	localparam logic [2:0] S_BTN   = 3'd6;

	logic [2:0]            state_q;
	logic [15:0]           tpm_q;
	logic [15:0]           tick_q;
	logic [ZONE_COUNT-1:0] valve_q;
	logic [ZONE_COUNT-1:0] has_q;
	logic [ZONE_COUNT-1:0] done_q;
	logic [ZW-1:0]         idx_q;
	logic [ZW-1:0]         zone_q;
	logic [ID_W-1:0]       cmd_id_q;
	logic [7:0]            now_q;
	logic [7:0]            cap_q;
	logic                  stop_had_q;

	logic [15:0]   dur_q  [ZONE_COUNT];
	logic [15:0]   elap_q [ZONE_COUNT];
	logic [ID_W-1:0] id_q [ZONE_COUNT];

	logic                  accept;
	logic                  in_range;
	logic [15:0]           alu_count;
	logic [15:0]           alu_limit;
	logic [15:0]           alu_next;
	logic                  alu_reached;
	logic                  walk_active;
	logic                  walk_done;
	logic                  walk_end;
	logic [ZW-1:0]         done_pick;
	logic [ZONE_COUNT-1:0] done_rest;
	logic [7:0]            btn_act;
	logic                  btn_found;
	logic [ZW-1:0]         btn_pick;
	logic [ZONE_COUNT-1:0] zone_bit;
	logic                  out_free;
	logic                  out_load;
	mzjt_pkg::report_t     out_rep;
	mzjt_pkg::report_t     load_rep;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign in_range  = (zone < 8'(ZONE_COUNT));
	assign cfg_ready = (state_q == S_IDLE);

	assign alu_count = (state_q == S_TICK) ? tick_q : elap_q[idx_q];
	assign alu_limit = (state_q == S_TICK) ? tpm_q : dur_q[idx_q];

	mzjt_alu u_alu (
		.count      (alu_count),
		.limit      (alu_limit),
		.count_next (alu_next),
		.reached    (alu_reached)
	);

	assign walk_active = has_q[idx_q] && (dur_q[idx_q] != 16'd0);
	assign walk_done   = walk_active && alu_reached;
	assign walk_end    = (idx_q == ZW'(ZONE_COUNT - 1));
	assign zone_bit    = ZONE_COUNT'(1) << zone_q;

	always_comb begin
		done_pick = '0;
		for (int i = ZONE_COUNT - 1; i >= 0; i--) begin
			if (done_q[i]) begin
				done_pick = ZW'(i);
			end
		end
		done_rest = done_q & ~(ZONE_COUNT'(1) << done_pick);
	end

	always_comb begin
		btn_act   = (~now_q != 8'd0) ? ~now_q : ~cap_q;
		btn_found = 1'b0;
		btn_pick  = '0;
		for (int i = ZONE_COUNT - 1; i >= 0; i--) begin
			if (btn_act[7 - i]) begin
				btn_found = 1'b1;
				btn_pick  = ZW'(i);
			end
		end
	end

	always_comb begin
		load_rep = '0;
		out_load = 1'b0;
		unique case (state_q)
			S_EMIT: begin
				out_load              = 1'b1;
				load_rep.kind         = mzjt_pkg::KIND_DONE;
				load_rep.zone         = 3'(done_pick);
				load_rep.job_id       = 32'(id_q[done_pick]);
				load_rep.job_id_valid = 1'b1;
				load_rep.valve_mask   = 8'(valve_q);
				load_rep.last         = (done_rest == '0);
			end
			S_STOP1: begin
				out_load              = 1'b1;
				load_rep.kind         = mzjt_pkg::KIND_STOP_ACK;
				load_rep.zone         = 3'(zone_q);
				load_rep.job_id       = 32'(cmd_id_q);
				load_rep.job_id_valid = 1'b1;
				load_rep.valve_mask   = 8'(valve_q & ~zone_bit);
			end
			S_STOP2: begin
				out_load              = 1'b1;
				load_rep.kind         = mzjt_pkg::KIND_DONE;
				load_rep.zone         = 3'(zone_q);
				load_rep.job_id       = stop_had_q ? 32'(id_q[zone_q]) : 32'd0;
				load_rep.job_id_valid = stop_had_q;
				load_rep.valve_mask   = 8'(valve_q);
				load_rep.last         = 1'b1;
			end
			S_BTN: begin
				out_load            = btn_found;
				load_rep.kind       = mzjt_pkg::KIND_TOGGLE;
				load_rep.zone       = 3'(btn_pick);
				load_rep.request_on = !valve_q[btn_pick];
				load_rep.valve_mask = 8'(valve_q);
				load_rep.last       = 1'b1;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	mzjt_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.load_data (load_rep),
		.free      (out_free),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_rep)
	);

	assign report_kind  = out_rep.kind;
	assign zone_out     = out_rep.zone;
	assign job_id_out   = out_rep.job_id;
	assign job_id_valid = out_rep.job_id_valid;
	assign request_on   = out_rep.request_on;
	assign valve_mask   = out_rep.valve_mask;
	assign last         = out_rep.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q <= mzjt_pkg::TPM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tpm_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tick_q     <= '0;
			valve_q    <= '0;
			has_q      <= '0;
			done_q     <= '0;
			idx_q      <= '0;
			stop_had_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (func)
							mzjt_pkg::FUNC_TICK: state_q <= S_TICK;
							mzjt_pkg::FUNC_START: begin
								if (in_range) begin
									has_q[zone[ZW-1:0]]   <= 1'b1;
									valve_q[zone[ZW-1:0]] <= 1'b1;
								end
							end
							mzjt_pkg::FUNC_STOP: begin
								if (in_range) begin
									state_q <= S_STOP1;
								end
							end
							mzjt_pkg::FUNC_BUTTON: state_q <= S_BTN;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_TICK: begin
					if (alu_reached) begin
						tick_q  <= '0;
						idx_q   <= '0;
						done_q  <= '0;
						state_q <= S_WALK;
					end else begin
						tick_q  <= alu_next;
						state_q <= S_IDLE;
					end
				end
				S_WALK: begin
					if (walk_done) begin
						done_q[idx_q]  <= 1'b1;
						valve_q[idx_q] <= 1'b0;
						has_q[idx_q]   <= 1'b0;
					end
					if (walk_end) begin
						state_q <= (done_q != '0 || walk_done) ? S_EMIT : S_IDLE;
					end else begin
						idx_q <= idx_q + ZW'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						done_q <= done_rest;
						if (done_rest == '0) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_STOP1: begin
					if (out_free) begin
						stop_had_q     <= has_q[zone_q];
						has_q[zone_q]  <= 1'b0;
						valve_q        <= valve_q & ~zone_bit;
						state_q        <= S_STOP2;
					end
				end
				S_STOP2: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_BTN: begin
					if (out_free || !btn_found) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			zone_q   <= zone[ZW-1:0];
			cmd_id_q <= cmd_id[ID_W-1:0];
			now_q    <= button_now;
			cap_q    <= button_captured;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && func == mzjt_pkg::FUNC_START && in_range) begin
			dur_q[zone[ZW-1:0]]  <= duration;
			elap_q[zone[ZW-1:0]] <= 16'd0;
			id_q[zone[ZW-1:0]]   <= cmd_id[ID_W-1:0];
		end else if (state_q == S_WALK && walk_active) begin
			if (alu_reached) begin
				dur_q[idx_q]  <= 16'd0;
				elap_q[idx_q] <= 16'd0;
			end else begin
				elap_q[idx_q] <= alu_next;
			end
		end else if (state_q == S_STOP1 && out_free) begin
			dur_q[zone_q]  <= 16'd0;
			elap_q[zone_q] <= 16'd0;
		end
	end

	logic [ZONE_COUNT-1:0] elap_bad;

	always_comb begin
		for (int i = 0; i < ZONE_COUNT; i++) begin
			elap_bad[i] = has_q[i] && (dur_q[i] != 16'd0) && (elap_q[i] >= dur_q[i]);
		end
	end

`ifndef SYNTHESIS
	a_valve_tracks_job: assert property (@(posedge clk) disable iff (!arst_n)
		valve_q == has_q)
		else $error("Valve bits disagree with the zones that hold a job.");

	a_elapsed_below_duration: assert property (@(posedge clk) disable iff (!arst_n)
		elap_bad == '0)
		else $error("A running zone has reached its duration without completing.");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> done_q == '0)
		else $error("Completion reports are pending while the sequencer is idle.");

	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> done_q != '0)
		else $error("The emit state has no completion to report.");
`endif

endmodule

// ===== rtl/mzjt_alu.sv =====
// Shared increment and compare unit used for the prescaler and every zone count.
`timescale 1ns / 1ps

module mzjt_alu (
	input  logic [15:0] count,
	input  logic [15:0] limit,
	output logic [15:0] count_next,
	output logic        reached
);

	assign count_next = count + 16'd1;
	assign reached    = (count_next >= limit);

endmodule

// ===== rtl/mzjt_out_reg.sv =====
// Output register that holds one report until the receiver takes it.
`timescale 1ns / 1ps

module mzjt_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  mzjt_pkg::report_t load_data,
	output logic              free,
	input  logic              out_stall,
	output logic              out_valid,
	output mzjt_pkg::report_t out_data
);

	logic              valid_q;
	mzjt_pkg::report_t data_q;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= load_data;
		end
	end

endmodule
